// ===== hdl/mfmsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mfmsd_pkg;

  localparam int unsigned MAX_LONGS_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [15:0] SYNC_RESET     = 16'h6cb1;
  localparam logic [31:0] EXP_SUM_RESET  = 32'h28f53cb9;
  localparam logic [12:0] LONGS_RESET    = 13'd1536;
  localparam logic [31:0] ODD_MASK       = 32'h55555555;

  // configuration register indexes
  localparam logic [1:0] REG_SYNC_PATTERN    = 2'd0;
  localparam logic [1:0] REG_EXPECTED_SUM    = 2'd1;
  localparam logic [1:0] REG_LONGS_PER_TRACK = 2'd2;

  // result kinds
  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic raw_bit;
    logic stream_end;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] data_word;
    logic [11:0] word_index;
    logic        last_word;
    logic        checksum_ok;
  } out_t;

  // request passed from the bit front end to the summing back end
  typedef struct packed {
    logic        kind;
    logic [31:0] data_word;
    logic [11:0] word_index;
    logic        last_word;
  } job_t;

endpackage
`default_nettype wire

// ===== hdl/mfm_sync_track_decoder_sum_check.sv =====
// MFM track decoder with sync hunt and additive checksum.
// bit channel: one raw MFM bit (or an end-of-stream marker) per request,
//   taken when bit_valid is high and bit_stall is low.
// word channel: one decoded longword or end report per request, taken
//   when word_valid is high and word_stall is low.
// cfg channel: register index and data, written when cfg_valid and
//   cfg_ready are both high; cfg_ready is always high. Index 0 sync word,
//   1 expected sum, 2 longwords per track; other indexes are ignored.
// Throughput: one bit per cycle while bit_stall is low. A result is registered in
//   the queue, then in the output register, after the bit that completes it is taken.
// A four-entry request queue sits between the bit front end and the summing
//   back end; bit_stall rises only when that queue is full, which needs
//   word_stall held while four more requests arrive behind the held result.
// Reset (rst, synchronous) restores register defaults, clears the sync
//   window, the track state, the running sum and the queue.
// While word_stall is high the current result holds and the front end
//   keeps absorbing bits until the queue fills.
`timescale 1ns / 1ps
`default_nettype none
module mfm_sync_track_decoder_sum_check #(
  parameter int unsigned MAX_LONGS = mfmsd_pkg::MAX_LONGS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           bit_valid,
  input  wire mfmsd_pkg::in_t bit_data,
  output logic                bit_stall,
  output logic                word_valid,
  output mfmsd_pkg::out_t     word_data,
  input  wire logic           word_stall,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);

  logic [15:0] sync_pattern;
  logic [31:0] expected_sum;
  logic [12:0] longs_per_track;

  logic            accept;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  mfmsd_pkg::job_t wr_job;
  mfmsd_pkg::job_t rd_job;

  assign cfg_ready = 1'b1;
  assign bit_stall = full;
  assign accept    = bit_valid && !bit_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern    <= mfmsd_pkg::SYNC_RESET;
      expected_sum    <= mfmsd_pkg::EXP_SUM_RESET;
      longs_per_track <= mfmsd_pkg::LONGS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfmsd_pkg::REG_SYNC_PATTERN:    sync_pattern    <= cfg_data[15:0];
        mfmsd_pkg::REG_EXPECTED_SUM:    expected_sum    <= cfg_data;
        mfmsd_pkg::REG_LONGS_PER_TRACK: longs_per_track <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  mfmsd_front #(
    .MAX_LONGS(MAX_LONGS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .bit_in          (bit_data),
    .sync_pattern    (sync_pattern),
    .longs_per_track (longs_per_track),
    .push            (push),
    .job             (wr_job)
  );

  mfmsd_fifo #(
    .DEPTH(mfmsd_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .full   (full),
    .empty  (empty)
  );

  mfmsd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_avail    (!empty),
    .job          (rd_job),
    .pop          (pop),
    .expected_sum (expected_sum),
    .out_valid    (word_valid),
    .out_data     (word_data),
    .out_stall    (word_stall)
  );

endmodule
`default_nettype wire

// ===== hdl/mfmsd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfmsd_front #(
  parameter int unsigned MAX_LONGS = mfmsd_pkg::MAX_LONGS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire mfmsd_pkg::in_t bit_in,
  input  wire logic [15:0]    sync_pattern,
  input  wire logic [12:0]    longs_per_track,
  output logic                push,
  output mfmsd_pkg::job_t     job
);

  localparam int unsigned CNT_W = (MAX_LONGS > 1) ? $clog2(MAX_LONGS) : 1;
  localparam int unsigned LIM_W = ($clog2(MAX_LONGS + 1) > 13) ? $clog2(MAX_LONGS + 1) : 13;
  localparam int unsigned IDX_W = (CNT_W > 12) ? CNT_W : 12;

  logic [15:0]      sync_window;
  logic             collecting;
  logic [5:0]       bit_position;
  logic [CNT_W-1:0] count;
  logic [31:0]      even_half;
  logic [31:0]      odd_half;

  logic [15:0]      window_next;
  logic [31:0]      odd_next;
  logic [LIM_W-1:0] lpt_ext;
  logic [LIM_W-1:0] limit;
  logic             last;
  logic             word_done;
  logic [IDX_W-1:0] count_ext;

  always_comb begin
    window_next = {sync_window[14:0], bit_in.raw_bit};
    odd_next    = {odd_half[30:0], bit_in.raw_bit};
    lpt_ext     = LIM_W'(longs_per_track);
    if (lpt_ext == '0) begin
      limit = LIM_W'(1);
    end else if (lpt_ext > LIM_W'(MAX_LONGS)) begin
      limit = LIM_W'(MAX_LONGS);
    end else begin
      limit = lpt_ext;
    end
    last      = (LIM_W'(count) + LIM_W'(1)) >= limit;
    word_done = collecting && (bit_position == 6'd63);
    count_ext = IDX_W'(count);

    push = accept && (bit_in.stream_end || word_done);
    if (bit_in.stream_end) begin
      job = '{kind: mfmsd_pkg::KIND_END, data_word: '0, word_index: '0, last_word: 1'b0};
    end else begin
      job.kind       = mfmsd_pkg::KIND_WORD;
      job.data_word  = ((even_half & mfmsd_pkg::ODD_MASK) << 1) |
                       (odd_next & mfmsd_pkg::ODD_MASK);
      job.word_index = count_ext[11:0];
      job.last_word  = last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_window  <= '0;
      collecting   <= 1'b0;
      bit_position <= '0;
      count        <= '0;
    end else if (accept) begin
      if (bit_in.stream_end) begin
        sync_window  <= '0;
        collecting   <= 1'b0;
        bit_position <= '0;
        count        <= '0;
      end else begin
        sync_window <= window_next;
        if (!collecting) begin
          if (window_next == sync_pattern) begin
            collecting   <= 1'b1;
            bit_position <= '0;
            count        <= '0;
          end
        end else if (!word_done) begin
          bit_position <= bit_position + 6'd1;
        end else if (last) begin
          collecting   <= 1'b0;
          bit_position <= '0;
          count        <= '0;
        end else begin
          bit_position <= '0;
          count        <= count + CNT_W'(1);
        end
      end
    end
  end

  // halves are fully refilled by 32 shifts each, so they need no clearing
  always_ff @(posedge clk) begin
    if (accept && !bit_in.stream_end && collecting) begin
      if (!bit_position[5]) begin
        even_half <= {even_half[30:0], bit_in.raw_bit};
      end else begin
        odd_half <= odd_next;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mfmsd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfmsd_fifo #(
  parameter int unsigned DEPTH = mfmsd_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire mfmsd_pkg::job_t wr_job,
  input  wire logic            pop,
  output mfmsd_pkg::job_t      rd_job,
  output logic                 full,
  output logic                 empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mfmsd_pkg::job_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("request queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("request queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("queue count did not rise");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
      (pop && !push) |=> count == $past(count) - CNT_W'(1))
    else $error("queue count did not fall");

endmodule
`default_nettype wire

// ===== hdl/mfmsd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mfmsd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_avail,
  input  wire mfmsd_pkg::job_t job,
  output logic                 pop,
  input  wire logic [31:0]     expected_sum,
  output logic                 out_valid,
  output mfmsd_pkg::out_t      out_data,
  input  wire logic            out_stall
);

  logic [31:0] running_sum;
  logic [31:0] sum_next;

  assign pop      = job_avail && (!out_valid || !out_stall);
  assign sum_next = running_sum + job.data_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      running_sum <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (job.kind == mfmsd_pkg::KIND_END || job.last_word) begin
          running_sum <= '0;
        end else begin
          running_sum <= sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (job.kind == mfmsd_pkg::KIND_END) begin
        out_data <= '{kind: mfmsd_pkg::KIND_END, data_word: '0, word_index: '0,
                      last_word: 1'b0, checksum_ok: 1'b0};
      end else begin
        out_data.kind        <= mfmsd_pkg::KIND_WORD;
        out_data.data_word   <= job.data_word;
        out_data.word_index  <= job.word_index;
        out_data.last_word   <= job.last_word;
        out_data.checksum_ok <= job.last_word && (sum_next == expected_sum);
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/mfm_sync_track_decoder_sum_check_tb.sv =====
`timescale 1ns / 1ps
module mfm_sync_track_decoder_sum_check_tb;

  localparam logic [1:0] REG_UNUSED   = 2'd3;
  localparam int         SETTLE       = 8;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         STUCK_LIMIT  = 5000;
  localparam int         REPORT_LIMIT = 40;
  localparam int         ITEMS        = 500;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            bit_valid = 1'b0;
  mfmsd_pkg::in_t  bit_data = '0;
  logic            bit_stall;
  logic            word_valid;
  mfmsd_pkg::out_t word_data;
  logic            word_stall = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [1:0]      cfg_index = '0;
  logic [31:0]     cfg_data = '0;

  mfm_sync_track_decoder_sum_check i_dut (
    .clk        (clk),
    .rst        (rst),
    .bit_valid  (bit_valid),
    .bit_data   (bit_data),
    .bit_stall  (bit_stall),
    .word_valid (word_valid),
    .word_data  (word_data),
    .word_stall (word_stall),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  // pending raw stream and decoded words still owed by the block
  mfmsd_pkg::in_t  raw_stream[$];
  mfmsd_pkg::out_t words_due[$];
  mfmsd_pkg::out_t head_word;

  // decoder copy: registers
  logic [15:0] p_sync;
  logic [31:0] p_sum;
  logic [12:0] p_len;
  // decoder copy: track state
  logic [15:0] win;
  logic        collecting;
  int          bitpos;
  int          longs;
  logic [31:0] even_w;
  logic [31:0] odd_w;
  logic [31:0] run_sum;

  // generator view of the registers
  logic [15:0] cur_sync = mfmsd_pkg::SYNC_RESET;
  logic [31:0] cur_sum  = mfmsd_pkg::EXP_SUM_RESET;
  int          cur_lim;

  bit steady  = 1'b0;
  bit hold_go = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int stuck = 0;

  int errors = 0;
  int bits_in = 0;
  int bits_queued = 0;
  int words_seen = 0;
  int sums_ok = 0;
  int ends_seen = 0;
  int cfg_writes = 0;

  function automatic int track_longs(input logic [12:0] n);
    if (n == 13'd0) return 1;
    if (32'(n) > mfmsd_pkg::MAX_LONGS_DEF) return int'(mfmsd_pkg::MAX_LONGS_DEF);
    return int'(n);
  endfunction

  function automatic void clear_track();
    collecting = 1'b0;
    bitpos     = 0;
    longs      = 0;
    even_w     = '0;
    odd_w      = '0;
    run_sum    = '0;
  endfunction

  task automatic decode_bit(input mfmsd_pkg::in_t b);
    mfmsd_pkg::out_t r;
    r = '0;
    if (b.stream_end) begin
      win = '0;
      clear_track();
      r.kind = mfmsd_pkg::KIND_END;
      words_due.push_back(r);
    end else begin
      win = {win[14:0], b.raw_bit};
      if (!collecting) begin
        if (win == p_sync) begin
          clear_track();
          collecting = 1'b1;
        end
      end else begin
        if (bitpos < 32) even_w = {even_w[30:0], b.raw_bit};
        else odd_w = {odd_w[30:0], b.raw_bit};
        if (bitpos < 63) begin
          bitpos++;
        end else begin
          r.kind        = mfmsd_pkg::KIND_WORD;
          r.data_word   = ((even_w & mfmsd_pkg::ODD_MASK) << 1) |
                          (odd_w & mfmsd_pkg::ODD_MASK);
          r.word_index  = longs[11:0];
          r.last_word   = (longs + 1) >= track_longs(p_len);
          run_sum       = run_sum + r.data_word;
          r.checksum_ok = r.last_word && (run_sum == p_sum);
          words_due.push_back(r);
          if (r.last_word) begin
            clear_track();
          end else begin
            longs++;
            bitpos = 0;
            even_w = '0;
            odd_w  = '0;
          end
        end
      end
    end
  endtask

  // ---- stream construction ----

  function automatic void push_bits(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) raw_stream.push_back(mfmsd_pkg::in_t'{v[i], 1'b0});
    bits_queued += n;
  endfunction

  function automatic void push_end(input logic raw);
    raw_stream.push_back(mfmsd_pkg::in_t'{raw, 1'b1});
    bits_queued++;
  endfunction

  // MFM-style cell layout: data bits on the mask positions, clock bits random
  function automatic void push_long(input logic [31:0] d);
    logic [31:0] ev, od;
    ev = ((d >> 1) & mfmsd_pkg::ODD_MASK) | ($urandom() & ~mfmsd_pkg::ODD_MASK);
    od = (d & mfmsd_pkg::ODD_MASK) | ($urandom() & ~mfmsd_pkg::ODD_MASK);
    push_bits({ev, od}, 64);
  endfunction

  // sync then n longwords; with hit the last word is chosen so the sum matches
  function automatic void add_track(input int n, input bit hit);
    logic [31:0] d, acc;
    acc = '0;
    push_bits({48'd0, cur_sync}, 16);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0:       d = 32'h0;
        1:       d = 32'hffff_ffff;
        default: d = $urandom();
      endcase
      if (hit && i == n - 1) d = cur_sum - acc;
      acc = acc + d;
      push_long(d);
    end
  endfunction

  function automatic void add_random_seq();
    int sel;
    sel = int'($urandom_range(99));
    if (sel < 70) begin
      push_bits(64'haaaa_aaaa_aaaa_aaaa, int'($urandom_range(24)));
      add_track(cur_lim, 1'($urandom_range(1)));
    end else if (sel < 80) begin
      push_bits({$urandom(), $urandom()}, int'($urandom_range(1, 64)));
    end else if (sel < 90) begin
      // track cut short by an end marker
      add_track(int'($urandom_range(cur_lim - 1)), 1'b0);
      push_bits({$urandom(), $urandom()}, int'($urandom_range(63)));
      push_end(1'($urandom_range(1)));
    end else begin
      repeat ($urandom_range(1, 5)) push_end(1'($urandom_range(1)));
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mfmsd_pkg::REG_SYNC_PATTERN:    cur_sync = val[15:0];
      mfmsd_pkg::REG_EXPECTED_SUM:    cur_sum  = val;
      mfmsd_pkg::REG_LONGS_PER_TRACK: cur_lim  = track_longs(val[12:0]);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (raw_stream.size() != 0 || bit_valid || words_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // ---- bit side: driver plus decoder copy ----
  always @(posedge clk) begin
    if (rst) begin
      bit_valid <= 1'b0;
      bit_data  <= '0;
      p_sync = mfmsd_pkg::SYNC_RESET;
      p_sum  = mfmsd_pkg::EXP_SUM_RESET;
      p_len  = mfmsd_pkg::LONGS_RESET;
      win    = '0;
      clear_track();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          mfmsd_pkg::REG_SYNC_PATTERN:    p_sync = cfg_data[15:0];
          mfmsd_pkg::REG_EXPECTED_SUM:    p_sum  = cfg_data;
          mfmsd_pkg::REG_LONGS_PER_TRACK: p_len  = cfg_data[12:0];
          default: ;
        endcase
      end
      if (bit_valid && !bit_stall) begin
        bits_in++;
        decode_bit(bit_data);
      end
      if (!bit_valid || !bit_stall) begin
        if (raw_stream.size() != 0 && (steady || $urandom_range(99) >= 8)) begin
          bit_data  <= raw_stream.pop_front();
          bit_valid <= 1'b1;
        end else begin
          bit_valid <= 1'b0;
        end
      end
    end
  end

  // ---- word side: receiver and compare ----
  always @(posedge clk) begin
    if (rst) begin
      word_stall <= 1'b0;
    end else begin
      if (word_valid && !word_stall) begin
        if (word_data.kind == mfmsd_pkg::KIND_END) ends_seen++;
        else words_seen++;
        if (word_data.checksum_ok) sums_ok++;
        if (words_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected result, expected none, got %p", $time, word_data);
        end else begin
          head_word = words_due.pop_front();
          check_field("kind", 32'(head_word.kind), 32'(word_data.kind));
          check_field("data_word", head_word.data_word, word_data.data_word);
          check_field("word_index", 32'(head_word.word_index), 32'(word_data.word_index));
          check_field("last_word", 32'(head_word.last_word), 32'(word_data.last_word));
          check_field("checksum_ok", 32'(head_word.checksum_ok),
                      32'(word_data.checksum_ok));
        end
      end
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        word_stall <= 1'b1;
      end else begin
        word_stall <= !steady && ($urandom_range(99) < 8);
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if (rst || (bit_valid && !bit_stall) || (word_valid && !word_stall) ||
        (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
  end

  initial begin
    wait (stuck >= STUCK_LIMIT);
    $display("%0t: no request moved for %0d cycles", $time, STUCK_LIMIT);
    $display("[mfm_sync_track_decoder_sum_check] ERROR");
    $finish;
  end

  initial begin
    cur_lim = track_longs(mfmsd_pkg::LONGS_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: end while hunting, then a track aborted after its sync
    push_end(1'b1);
    push_bits(64'ha, 4);
    add_track(0, 1'b0);
    push_bits({$urandom(), $urandom()}, 20);
    push_end(1'b1);

    // all-ones sync, length 0 taken as 1: the end marker clears the window,
    // and after a track the window still matches, so only the next bit resyncs
    wait_idle();
    write_reg(mfmsd_pkg::REG_SYNC_PATTERN, 32'h0000_ffff);
    write_reg(mfmsd_pkg::REG_EXPECTED_SUM, 32'hffff_ffff);
    write_reg(mfmsd_pkg::REG_LONGS_PER_TRACK, 32'd0);
    push_bits(64'h7fff, 15);
    push_end(1'b1);
    push_bits(64'hffff, 16);
    push_bits(64'hffff_ffff_ffff_ffff, 64);
    push_bits(64'd1, 1);
    push_long(32'h1234_5678);
    push_end(1'b0);

    // unused index ignored; oversize length saturates, so the word is not last
    wait_idle();
    write_reg(REG_UNUSED, $urandom());
    write_reg(mfmsd_pkg::REG_SYNC_PATTERN, 32'h5a5a_6cb1);
    write_reg(mfmsd_pkg::REG_LONGS_PER_TRACK, 32'hffff_ffff);
    add_track(1, 1'b0);
    push_end(1'b0);

    // end markers pile up behind a long output hold
    wait_idle();
    write_reg(mfmsd_pkg::REG_SYNC_PATTERN, $urandom());
    write_reg(mfmsd_pkg::REG_EXPECTED_SUM, $urandom());
    write_reg(mfmsd_pkg::REG_LONGS_PER_TRACK, 32'd1);
    repeat (12) push_end(1'($urandom_range(1)));
    add_track(cur_lim, 1'b1);
    hold_go = !hold_go;

    for (int s = 0; s < 2 || bits_queued < ITEMS; s++) begin
      wait_idle();
      write_reg(mfmsd_pkg::REG_SYNC_PATTERN, $urandom());
      write_reg(mfmsd_pkg::REG_EXPECTED_SUM, (s == 2) ? 32'h0 : $urandom());
      write_reg(mfmsd_pkg::REG_LONGS_PER_TRACK, 32'($urandom_range(1, 2)));
      steady = (s == 1);
      if (steady) add_track(cur_lim, 1'b1);
      else add_random_seq();
    end
    steady = 1'b0;

    wait_idle();
    $display("covered %0d raw bits, %0d register writes", bits_in, cfg_writes);
    $display("%0d longwords (%0d sum matches), %0d stream ends", words_seen, sums_ok,
             ends_seen);
    if (errors == 0)
      $display("[mfm_sync_track_decoder_sum_check] OK");
    else
      $display("[mfm_sync_track_decoder_sum_check] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mfmsd_pkg.sv
hdl/mfmsd_front.sv
hdl/mfmsd_fifo.sv
hdl/mfmsd_back.sv
hdl/mfm_sync_track_decoder_sum_check.sv
bench/mfm_sync_track_decoder_sum_check_tb.sv
